// ----- src/htpi_pkg.sv -----
// Shared types and codes for the hash table probe and insert block.
`default_nettype none

package htpi_pkg;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   typedef enum logic [2:0] {
      ST_NEW       = 3'd0,
      ST_REPLACED  = 3'd1,
      ST_FOUND     = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_FULL      = 3'd4,
      ST_ZERO_KEY  = 3'd5
   } rsp_status_type;

   typedef struct packed {
      logic clr_wr;
      logic load;
      logic mem_rd;
      logic advance;
      logic mem_wr;
      logic res_zero;
      logic res_check;
      logic out_load;
   } htpi_cmd_type;

   typedef struct packed {
      logic key_zero;
      logic slot_stop;
      logic probe_last;
      logic clr_last;
      logic out_free;
      logic op_insert;
   } htpi_stat_type;

endpackage

`default_nettype wire

// ----- src/hash_table_probe_insert.sv -----
// Top level of the open-addressing hash table with perturbed probing.
//
//  Channel  Direction  tdata (low bit up)                  tuser
//  req      in         key, key_hash, value (96 bits)       opcode
//  rsp      out        slot_index, data_out, zero padding   status
//
// After reset the table is cleared one slot per cycle, all 2**SLOT_BITS slots, with req_tready low.
// A request is accepted, each probed slot is read and then compared, then its result is posted.
// A zero key skips probing; its result is registered at acceptance and posted like any other.
// The slot memory has one read port, so probes of a request are strictly sequential.
// A posted result waits in the output register while the next request is accepted and probed.
`default_nettype none

module hash_table_probe_insert
   import htpi_pkg::*;
#(
   parameter int SLOT_BITS   = 10,
   parameter int PROBE_LIMIT = 1040,
   localparam int RSP_W      = ((SLOT_BITS + 32 + 7) / 8) * 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [95:0]      req_tdata,   // key, key_hash, value
   input  wire logic [0:0]       req_tuser,   // opcode
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,   // slot_index, data_out, zero padding
   output logic [2:0]            rsp_tuser    // status
);

   htpi_cmd_type         cmd;
   htpi_stat_type        stat;
   rsp_status_type       rsp_status;
   logic [SLOT_BITS-1:0] rsp_slot;
   logic [31:0]          rsp_data;

   htpi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   htpi_dp #(
      .SLOT_BITS   (SLOT_BITS),
      .PROBE_LIMIT (PROBE_LIMIT)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_op     (req_tuser[0]),
      .req_key    (req_tdata[31:0]),
      .req_hash   (req_tdata[63:32]),
      .req_value  (req_tdata[95:64]),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_status (rsp_status),
      .rsp_slot   (rsp_slot),
      .rsp_data   (rsp_data)
   );

   assign rsp_tdata = RSP_W'({rsp_data, rsp_slot});
   assign rsp_tuser = rsp_status;

endmodule

`default_nettype wire

// ----- src/htpi_ctrl.sv -----
// Controller state machine that sequences clearing, probing and result delivery.
`default_nettype none

module htpi_ctrl
   import htpi_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   output htpi_cmd_type       cmd,
   input  wire htpi_stat_type stat
);

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_READ  = 5'b00100,
      S_CHECK = 5'b01000,
      S_RESP  = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;
   logic      done_check;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tready && req_tvalid;
   assign done_check = stat.slot_stop || stat.probe_last;

   always_comb begin
      cmd           = '0;
      cmd.clr_wr    = (state_ff == S_CLEAR);
      cmd.load      = accept;
      cmd.res_zero  = accept && stat.key_zero;
      cmd.mem_rd    = (state_ff == S_READ);
      cmd.advance   = (state_ff == S_CHECK) && !done_check;
      cmd.res_check = (state_ff == S_CHECK) && done_check;
      cmd.mem_wr    = (state_ff == S_CHECK) && stat.slot_stop && stat.op_insert;
      cmd.out_load  = (state_ff == S_RESP) && stat.out_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (stat.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = stat.key_zero ? S_RESP : S_READ;
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            state_in = done_check ? S_RESP : S_READ;
         end
         S_RESP: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   a_no_write_during_clear: assert property (@(posedge clock) disable iff (reset)
      !(cmd.clr_wr && cmd.mem_wr))
      else $error("Table write issued during the clearing pass.");

   a_accept_starts_work: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_READ || state_ff == S_RESP))
      else $error("Accepted request did not start a probe or a result.");

   a_check_follows_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK) |-> ($past(state_ff) == S_READ))
      else $error("Slot compare without a preceding slot read.");

endmodule

`default_nettype wire

// ----- src/htpi_dp.sv -----
// Datapath with the slot memory, probe sequence registers and result registers.
`default_nettype none

module htpi_dp
   import htpi_pkg::*;
#(
   parameter int SLOT_BITS   = 10,
   parameter int PROBE_LIMIT = 1040
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_op,
   input  wire logic [31:0]          req_key,
   input  wire logic [31:0]          req_hash,
   input  wire logic [31:0]          req_value,
   input  wire htpi_cmd_type         cmd,
   output htpi_stat_type             stat,
   input  wire logic                 rsp_tready,
   output logic                      rsp_valid,
   output rsp_status_type            rsp_status,
   output logic [SLOT_BITS-1:0]      rsp_slot,
   output logic [31:0]               rsp_data
);

   localparam int SLOTS = 1 << SLOT_BITS;
   localparam int CNT_W = $clog2(PROBE_LIMIT);

   logic [63:0]          slot_mem [SLOTS];
   logic [63:0]          rd_ff;
   logic                 op_ff;
   logic [31:0]          key_ff;
   logic [31:0]          value_ff;
   logic [31:0]          perturb_ff;
   logic [SLOT_BITS-1:0] idx_ff;
   logic [SLOT_BITS-1:0] idx_next;
   logic [CNT_W-1:0]     cnt_ff;
   logic [SLOT_BITS-1:0] clr_ff;
   logic                 key_match;
   logic                 slot_empty;
   logic                 mem_we;
   logic [SLOT_BITS-1:0] wr_addr;
   logic [63:0]          wr_data;

   rsp_status_type       res_status_ff;
   rsp_status_type       res_status_in;
   logic [SLOT_BITS-1:0] res_slot_ff;
   logic [SLOT_BITS-1:0] res_slot_in;
   logic [31:0]          res_data_ff;
   logic [31:0]          res_data_in;

   logic                 rsp_valid_ff;
   rsp_status_type       rsp_status_ff;
   logic [SLOT_BITS-1:0] rsp_slot_ff;
   logic [31:0]          rsp_data_ff;

   assign key_match  = (rd_ff[31:0] == key_ff);
   assign slot_empty = (rd_ff[31:0] == 32'd0);
   assign idx_next   = (idx_ff << 2) + idx_ff + perturb_ff[SLOT_BITS-1:0] + SLOT_BITS'(1);

   always_comb begin
      stat            = '0;
      stat.key_zero   = (req_key == 32'd0);
      stat.slot_stop  = key_match || slot_empty;
      stat.probe_last = (cnt_ff == CNT_W'(PROBE_LIMIT - 1));
      stat.clr_last   = (clr_ff == {SLOT_BITS{1'b1}});
      stat.out_free   = !rsp_valid_ff || rsp_tready;
      stat.op_insert  = (op_ff == OP_INSERT);
   end

   assign mem_we  = cmd.clr_wr || cmd.mem_wr;
   assign wr_addr = cmd.clr_wr ? clr_ff : idx_ff;
   assign wr_data = cmd.clr_wr ? 64'd0 : {value_ff, key_ff};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[wr_addr] <= wr_data;
      end
      if (cmd.mem_rd) begin
         rd_ff <= slot_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_wr) begin
         clr_ff <= clr_ff + SLOT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= req_op;
         key_ff     <= req_key;
         value_ff   <= req_value;
         perturb_ff <= req_hash;
         idx_ff     <= req_hash[SLOT_BITS-1:0];
         cnt_ff     <= '0;
      end else if (cmd.advance) begin
         perturb_ff <= perturb_ff >> 2;
         idx_ff     <= idx_next;
         cnt_ff     <= cnt_ff + CNT_W'(1);
      end
   end

   always_comb begin
      res_status_in = ST_NOT_FOUND;
      res_slot_in   = '0;
      res_data_in   = 32'd0;
      if (cmd.res_zero) begin
         res_status_in = ST_ZERO_KEY;
      end else if (key_match || slot_empty) begin
         if (op_ff == OP_INSERT) begin
            res_status_in = key_match ? ST_REPLACED : ST_NEW;
            res_slot_in   = idx_ff;
            res_data_in   = key_match ? rd_ff[63:32] : 32'd0;
         end else if (key_match) begin
            res_status_in = ST_FOUND;
            res_slot_in   = idx_ff;
            res_data_in   = rd_ff[63:32];
         end
      end else if (op_ff == OP_INSERT) begin
         res_status_in = ST_FULL;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.res_zero || cmd.res_check) begin
         res_status_ff <= res_status_in;
         res_slot_ff   <= res_slot_in;
         res_data_ff   <= res_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_slot_ff   <= res_slot_ff;
         rsp_data_ff   <= res_data_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot   = rsp_slot_ff;
   assign rsp_data   = rsp_data_ff;

   a_status_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_status_ff <= ST_ZERO_KEY))
      else $error("Response status code out of range.");

   a_miss_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ST_NOT_FOUND || rsp_status_ff == ST_FULL ||
                        rsp_status_ff == ST_ZERO_KEY))
      |-> (rsp_slot_ff == '0 && rsp_data_ff == 32'd0))
      else $error("Response without a slot carries a slot or data.");

   a_write_at_stop_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_wr |-> (key_match || slot_empty))
      else $error("Insert writes a slot that holds another key.");

endmodule

`default_nettype wire
